// ===== design/z85_pkg.sv =====
// ============================================================================
// z85_pkg - shared types and constants of the Z85 stream encoder
// Alphabet table, reciprocal constants for the base-85 split and the records
// passed between the front end, the job queue, the converter and the emitter.
// ============================================================================
`default_nettype none

package z85_pkg;

  // Job queue depth between the byte front end and the converter (>= 2)
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned DIGIT_W    = 7;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned PARTIAL_W  = 24;
  localparam int unsigned GROUP_CHARS = 5;

  // 85^2, the split point of a 32-bit word into a high and a low part
  localparam int unsigned POW85_2 = 7225;
  localparam int unsigned RADIX   = 85;

  // floor(n / 7225) = (n * RECIP_7225) >> 44, exact for n < 2^32
  localparam int unsigned   DIV7225_SHIFT = 44;
  localparam logic [31:0]   RECIP_7225    = 32'd2434904643;
  // high part of a word: floor((2^32 - 1) / 7225) fits in 20 bits
  localparam int unsigned   HI_W          = 20;
  // anything below 7225 fits in 13 bits
  localparam int unsigned   LO_W          = 13;

  // floor(n / 85) = (n * RECIP_85) >> 20, exact for n < 2^13
  localparam int unsigned   DIV85_SHIFT   = 20;
  localparam logic [13:0]   RECIP_85      = 14'd12337;

  typedef logic [DIGIT_W-1:0] z85_digit_t;
  typedef logic [CHAR_W-1:0]  z85_char_t;

  // Z85 alphabet, indexed by base-85 digit
  localparam logic [7:0] Z85_ALPHABET [RADIX] = '{
    "0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
    "a", "b", "c", "d", "e", "f", "g", "h", "i", "j",
    "k", "l", "m", "n", "o", "p", "q", "r", "s", "t",
    "u", "v", "w", "x", "y", "z",
    "A", "B", "C", "D", "E", "F", "G", "H", "I", "J",
    "K", "L", "M", "N", "O", "P", "Q", "R", "S", "T",
    "U", "V", "W", "X", "Y", "Z",
    ".", "-", ":", "+", "=", "^", "!", "/", "*", "?",
    "&", "<", ">", "(", ")", "[", "]", "{", "}", "@",
    "%", "$", "#"
  };

  // Map one base-85 digit to its alphabet character
  function automatic z85_char_t z85_char(input z85_digit_t digit);
    logic [7:0] code;
    code = Z85_ALPHABET[digit];
    return code[CHAR_W-1:0];
  endfunction

  // One unit of work for the converter: a full group or a length error
  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              frame_end;
    logic              is_error;
  } z85_job_t;

  // Converted group: digit[0] is the most significant base-85 digit
  typedef struct packed {
    logic [GROUP_CHARS-1:0][DIGIT_W-1:0] digit;
    logic                                frame_end;
    logic                                is_error;
  } z85_digits_t;

endpackage

`default_nettype wire

// ===== design/z85_in_if.sv =====
// ============================================================================
// z85_in_if - byte input channel of the Z85 encoder
// Valid/ready channel carrying one raw byte and its end-of-frame flag.
// ============================================================================
`default_nettype none

interface z85_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== design/z85_out_if.sv =====
// ============================================================================
// z85_out_if - character output channel of the Z85 encoder
// Valid/ready channel carrying one alphabet character and its markers.
// ============================================================================
`default_nettype none

interface z85_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       group_last;
  logic       frame_last;
  logic       length_error;

  modport source (output valid, output out_char, output group_last,
                  output frame_last, output length_error, input ready);
  modport sink   (input valid, input out_char, input group_last,
                  input frame_last, input length_error, output ready);
endinterface

`default_nettype wire

// ===== design/z85_front.sv =====
// ============================================================================
// z85_front - byte collector
// Gathers bytes into groups of four, first byte most significant, and pushes
// a conversion job per full group, or an error job when a frame ends short.
// ============================================================================
`default_nettype none

module z85_front import z85_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  z85_in_if.sink    in_i,
  output z85_job_t  job_o,
  output logic      job_push_o,
  input  logic      job_full_i
);

  logic [PARTIAL_W-1:0] partial_q, partial_d;
  logic [1:0]           count_q, count_d;
  logic                 accept;

  // Take a byte whenever the queue has room for the job it may produce
  assign in_i.ready = !job_full_i;
  assign accept     = in_i.valid && in_i.ready;

  // Classify the byte: complete group, short frame, or plain collect
  always_comb begin
    partial_d  = partial_q;
    count_d    = count_q;
    job_push_o = 1'b0;
    job_o      = '{value:     {partial_q, in_i.data_byte},
                   frame_end: in_i.frame_end,
                   is_error:  1'b0};
    if (accept) begin
      if (count_q == 2'd3) begin
        job_push_o = 1'b1;
        count_d    = 2'd0;
      end else if (in_i.frame_end) begin
        job_o.is_error = 1'b1;
        job_push_o     = 1'b1;
        count_d        = 2'd0;
      end else begin
        partial_d = {partial_q[PARTIAL_W-BYTE_W-1:0], in_i.data_byte};
        count_d   = count_q + 2'd1;
      end
    end
  end

  // Hold the byte count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // Hold the bytes of the open group
  always_ff @(posedge clk_i) begin
    partial_q <= partial_d;
  end

endmodule

`default_nettype wire

// ===== design/z85_queue.sv =====
// ============================================================================
// z85_queue - job queue
// Small first-in first-out store of jobs between the collector and the
// converter, so that either side may stall without holding up the other.
// ============================================================================
`default_nettype none

module z85_queue import z85_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  z85_job_t job_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output z85_job_t head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  z85_job_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q, count_d;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
    return (ptr == PtrW'(Depth - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Track fill level
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
    end
  end

  // Store the incoming job
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/z85_conv.sv =====
// ============================================================================
// z85_conv - base-85 converter
// Splits a 32-bit word into five base-85 digits by reciprocal multiplication:
// first by 85^2 into a high and a low part, then each part by 85^2 and 85.
// One job in flight, steps SPLIT to DIG2, a register after each multiply.
// ============================================================================
`default_nettype none

module z85_conv import z85_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  z85_job_t    head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output z85_digits_t res_o,
  output logic        res_valid_o,
  input  logic        res_ready_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPLIT,
    S_MUL2,
    S_DIG1,
    S_MUL3,
    S_DIG2,
    S_ERR
  } state_e;

  state_e              state_q, state_d;
  z85_digits_t         res_q, res_d;
  logic                res_valid_q, res_valid_d;

  // Datapath registers
  logic [WORD_W-1:0]   value_q;
  logic                fend_q;
  logic [2*WORD_W-1:0] prod1_q;
  logic [HI_W-1:0]     hi_q;
  logic [LO_W-1:0]     lo_q;
  logic [HI_W+WORD_W-1:0] prod_hi_q;
  logic [LO_W+13:0]    prod_lo_q;
  logic [LO_W-1:0]     mid_q;
  logic [LO_W+13:0]    prod_mid_q;
  z85_digit_t          d0_q, d3_q, d4_q;

  // Combinational digit extraction
  logic [HI_W-1:0]     split_hi;
  logic [LO_W-1:0]     split_lo;
  z85_digit_t          d0, d3, d4, d1, d2;
  logic [LO_W-1:0]     mid;
  logic                hand_free;
  logic                pop;

  // High part = value / 85^2, low part = value mod 85^2
  assign split_hi = prod1_q[DIV7225_SHIFT +: HI_W];
  assign split_lo = LO_W'(value_q - WORD_W'(split_hi) * WORD_W'(POW85_2));

  // Most significant digit and middle remainder from the high part
  assign d0  = prod_hi_q[DIV7225_SHIFT +: DIGIT_W];
  assign mid = LO_W'(hi_q - HI_W'(d0) * HI_W'(POW85_2));

  // Two low digits from the low part
  assign d3 = prod_lo_q[DIV85_SHIFT +: DIGIT_W];
  assign d4 = DIGIT_W'(lo_q - LO_W'(d3) * LO_W'(RADIX));

  // Two middle digits from the middle remainder
  assign d1 = prod_mid_q[DIV85_SHIFT +: DIGIT_W];
  assign d2 = DIGIT_W'(mid_q - LO_W'(d1) * LO_W'(RADIX));

  assign hand_free = !res_valid_q || res_ready_i;
  assign pop = !empty_i &&
               ((state_q == S_IDLE) || ((state_q == S_DIG2) && hand_free));
  assign pop_o       = pop;
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  // Sequence the conversion steps and the hand-over to the emitter
  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (pop) begin
          state_d = head_i.is_error ? S_ERR : S_SPLIT;
        end
      end
      S_SPLIT: state_d = S_MUL2;
      S_MUL2:  state_d = S_DIG1;
      S_DIG1:  state_d = S_MUL3;
      S_MUL3:  state_d = S_DIG2;
      S_DIG2: begin
        if (hand_free) begin
          res_d.digit[0]  = d0_q;
          res_d.digit[1]  = d1;
          res_d.digit[2]  = d2;
          res_d.digit[3]  = d3_q;
          res_d.digit[4]  = d4_q;
          res_d.frame_end = fend_q;
          res_d.is_error  = 1'b0;
          res_valid_d     = 1'b1;
          if (pop) begin
            state_d = head_i.is_error ? S_ERR : S_SPLIT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (hand_free) begin
          res_d.digit     = '0;
          res_d.frame_end = 1'b1;
          res_d.is_error  = 1'b1;
          res_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and the hand-over register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Advance the datapath one step per state
  always_ff @(posedge clk_i) begin
    if (pop) begin
      value_q <= head_i.value;
      fend_q  <= head_i.frame_end;
      prod1_q <= (2*WORD_W)'(head_i.value) * (2*WORD_W)'(RECIP_7225);
    end
    if (state_q == S_SPLIT) begin
      hi_q <= split_hi;
      lo_q <= split_lo;
    end
    if (state_q == S_MUL2) begin
      prod_hi_q <= (HI_W+WORD_W)'(hi_q) * (HI_W+WORD_W)'(RECIP_7225);
      prod_lo_q <= (LO_W+14)'(lo_q) * (LO_W+14)'(RECIP_85);
    end
    if (state_q == S_DIG1) begin
      d0_q  <= d0;
      mid_q <= mid;
      d3_q  <= d3;
      d4_q  <= d4;
    end
    if (state_q == S_MUL3) begin
      prod_mid_q <= (LO_W+14)'(mid_q) * (LO_W+14)'(RECIP_85);
    end
  end

endmodule

`default_nettype wire

// ===== design/z85_emit.sv =====
// ============================================================================
// z85_emit - character emitter
// Serialises a converted group into five alphabet characters, most
// significant digit first, or one error result, through an output register.
// ============================================================================
`default_nettype none

module z85_emit import z85_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  z85_digits_t res_i,
  input  logic        res_valid_i,
  output logic        res_ready_o,
  z85_out_if.source   out_o
);

  logic [GROUP_CHARS-1:0][DIGIT_W-1:0] buf_q;
  logic                                fend_q, err_q;
  logic [2:0]                          left_q;

  logic      ovalid_q;
  z85_char_t char_q;
  logic      glast_q, flast_q, lerr_q;

  logic out_free, busy, last, emit, load;

  assign out_free    = !ovalid_q || out_o.ready;
  assign busy        = (left_q != 3'd0);
  assign last        = (left_q == 3'd1);
  assign emit        = busy && out_free;
  assign res_ready_o = !busy || (emit && last);
  assign load        = res_valid_i && res_ready_o;

  assign out_o.valid        = ovalid_q;
  assign out_o.out_char     = char_q;
  assign out_o.group_last   = glast_q;
  assign out_o.frame_last   = flast_q;
  assign out_o.length_error = lerr_q;

  // Count characters left in the group and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= 3'd0;
      ovalid_q <= 1'b0;
    end else begin
      if (load) begin
        left_q <= res_i.is_error ? 3'd1 : 3'(GROUP_CHARS);
      end else if (emit) begin
        left_q <= left_q - 3'd1;
      end
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Load a group, shift out one digit per transfer slot
  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q  <= res_i.digit;
      fend_q <= res_i.frame_end;
      err_q  <= res_i.is_error;
    end else if (emit) begin
      buf_q <= buf_q >> DIGIT_W;
    end
    if (emit) begin
      if (err_q) begin
        char_q  <= '0;
        glast_q <= 1'b1;
        flast_q <= 1'b1;
        lerr_q  <= 1'b1;
      end else begin
        char_q  <= z85_char(buf_q[0]);
        glast_q <= last;
        flast_q <= last && fend_q;
        lerr_q  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/z85_encoder_top.sv =====
// ============================================================================
// z85_encoder_top - streaming Z85 encoder
// Bytes in, Z85 alphabet characters out, four bytes to five characters.
// ============================================================================
// One byte is taken per cycle while the job queue has room. Every fourth
// byte closes a group, first byte most significant, and the group leaves as
// five characters, most significant base-85 digit first, with group_last on
// the fifth and frame_last on it when that byte ends the frame. A frame that
// ends part-way through a group yields one result with out_char 0 and
// group_last, frame_last and length_error set, and the group is dropped.
// The converter takes each group through its steps (a 32x32 reciprocal
// multiply, then narrow multiply steps) and the emitter sends one character
// per cycle while the output is ready, five characters per group. The first
// character of a group follows its last byte through the queue, the converter
// states and the emitter's output register. QueueDepth sets how many finished
// groups may wait for the converter (at least two).
// ============================================================================
`default_nettype none

module z85_encoder_top import z85_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  z85_in_if.sink    in_i,
  z85_out_if.source out_o
);

  z85_job_t    push_job, head_job;
  logic        push, full, pop, empty;
  z85_digits_t digits;
  logic        digits_valid, digits_ready;

  // Collect bytes into groups
  z85_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .job_o      (push_job),
    .job_push_o (push),
    .job_full_i (full)
  );

  // Decouple collection from conversion
  z85_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_job)
  );

  // Split each word into base-85 digits
  z85_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .empty_i     (empty),
    .pop_o       (pop),
    .res_o       (digits),
    .res_valid_o (digits_valid),
    .res_ready_i (digits_ready)
  );

  // Send characters out
  z85_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (digits),
    .res_valid_i (digits_valid),
    .res_ready_o (digits_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
